// ===== rtl/lr_pkg.sv =====
// Shared constants and types for the line rasterizer.
// No dependencies; every other file imports this package.
`default_nettype none

package lr_pkg;

    // Coordinate width of the image, default build.
    localparam int COORD_BITS_DEF = 12;

    // Fixed widths of the input beat.
    localparam int IN_COORD_BITS = 16;
    localparam int COLOR_BITS    = 8;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMG_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMG_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONNECTIVITY = 2'd2;

    // Width of a configuration register, whatever the coordinate width.
    localparam int CFG_DATA_BITS = 13;

    // Image size after reset, in pixels per side.
    localparam int RESET_SIZE = 1024;

    // Input beat kinds.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Stepping modes.
    localparam logic CONN_8 = 1'b0;
    localparam logic CONN_4 = 1'b1;

    // Line set-up flags handed from set-up to walker.
    typedef struct packed {
        logic ok;        // both endpoints inside the image
        logic x_major;   // x is the major axis
        logic y_neg;     // y steps toward lower values
        logic conn;      // stepping mode latched at start
    } lr_flags_t;

endpackage

`default_nettype wire

// ===== rtl/lr_in_if.sv =====
// Input channel of the line rasterizer: start and tick beats.
// Depends on lr_pkg.
`default_nettype none

interface lr_in_if;
    import lr_pkg::*;

    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [IN_COORD_BITS-1:0]  start_x;
    logic signed [IN_COORD_BITS-1:0]  start_y;
    logic signed [IN_COORD_BITS-1:0]  end_x;
    logic signed [IN_COORD_BITS-1:0]  end_y;
    logic        [COLOR_BITS-1:0]     color;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y, color,
        input  ready
    );

    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y, color,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/lr_out_if.sv =====
// Output channel of the line rasterizer: one pixel per beat.
// Depends on lr_pkg.
`default_nettype none

interface lr_out_if #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
);
    import lr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pix_x;
    logic [COORD_BITS-1:0]  pix_y;
    logic [COLOR_BITS-1:0]  pix_color;
    logic                   last;

    modport source (
        output valid, pix_x, pix_y, pix_color, last,
        input  ready
    );

    modport sink (
        input  valid, pix_x, pix_y, pix_color, last,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/lr_cfg_if.sv =====
// Configuration write channel of the line rasterizer.
// Depends on lr_pkg.
`default_nettype none

interface lr_cfg_if #(
    parameter int DATA_BITS = lr_pkg::CFG_DATA_BITS
);
    import lr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_BITS-1:0]  index;
    logic [DATA_BITS-1:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer.
// Depends on lr_pkg, lr_in_if, lr_out_if, lr_cfg_if, lr_cfg_regs, lr_setup, lr_walker.
`default_nettype none

// The block takes one input beat per clock. A start beat (mode 0) loads a line
// and gives no pixel; a line with any endpoint outside the image is dropped.
// Each tick beat (mode 1) while a line is active gives one pixel beat in the next
// cycle from the output register, with last set on the final pixel; ticks with
// no active line give nothing. Throughput is one beat per cycle, set by the
// single walker stage that steps the line state; the input stalls only while a
// finished pixel waits at the output and the sink holds ready low. Configuration
// writes are taken at once and must come while the block is idle.
module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lr_cfg_if.sink    cfg,
    lr_in_if.sink     item,
    lr_out_if.source  pixel
);
    import lr_pkg::*;

    logic [COORD_BITS:0]          width_lim;
    logic [COORD_BITS:0]          height_lim;
    logic                         conn;
    lr_flags_t                    flags;
    logic [COORD_BITS-1:0]        first_x;
    logic [COORD_BITS-1:0]        first_y;
    logic [COORD_BITS:0]          major_delta;
    logic [COORD_BITS:0]          minor_delta;
    logic signed [COORD_BITS+2:0] error_init;
    logic [COORD_BITS:0]          pixel_count;

    lr_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .conn       (conn)
    );

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x     (item.start_x),
        .start_y     (item.start_y),
        .end_x       (item.end_x),
        .end_y       (item.end_y),
        .width_lim   (width_lim),
        .height_lim  (height_lim),
        .conn        (conn),
        .flags       (flags),
        .first_x     (first_x),
        .first_y     (first_y),
        .major_delta (major_delta),
        .minor_delta (minor_delta),
        .error_init  (error_init),
        .pixel_count (pixel_count)
    );

    lr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_ready  (item.ready),
        .mode        (item.mode),
        .color       (item.color),
        .flags       (flags),
        .first_x     (first_x),
        .first_y     (first_y),
        .major_delta (major_delta),
        .minor_delta (minor_delta),
        .error_init  (error_init),
        .pixel_count (pixel_count),
        .out_valid   (pixel.valid),
        .out_ready   (pixel.ready),
        .pix_x       (pixel.pix_x),
        .pix_y       (pixel.pix_y),
        .pix_color   (pixel.pix_color),
        .last        (pixel.last)
    );

endmodule

`default_nettype wire

// ===== rtl/lr_cfg_regs.sv =====
// Configuration registers: image size and stepping mode, with size clamping.
// Depends on lr_pkg and lr_cfg_if.
`default_nettype none

module lr_cfg_regs #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    lr_cfg_if.sink               cfg,
    output logic [COORD_BITS:0]  width_lim,
    output logic [COORD_BITS:0]  height_lim,
    output logic                 conn
);
    import lr_pkg::*;

    localparam int SIZE_BITS = COORD_BITS + 1;
    localparam int REG_BITS  = CFG_DATA_BITS;
    localparam int CMP_W     = (REG_BITS > SIZE_BITS) ? REG_BITS : SIZE_BITS;
    localparam logic [CMP_W-1:0]    MAX_SIZE  = CMP_W'(1) << COORD_BITS;
    localparam logic [REG_BITS-1:0] INIT_SIZE = REG_BITS'(RESET_SIZE);

    logic [REG_BITS-1:0] width_reg;
    logic [REG_BITS-1:0] height_reg;
    logic                conn_reg;
    logic [CMP_W-1:0]    width_ext;
    logic [CMP_W-1:0]    height_ext;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= INIT_SIZE;
            height_reg <= INIT_SIZE;
            conn_reg   <= CONN_8;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IMG_WIDTH:    width_reg  <= cfg.data[REG_BITS-1:0];
                CFG_IMG_HEIGHT:   height_reg <= cfg.data[REG_BITS-1:0];
                CFG_CONNECTIVITY: conn_reg   <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    assign width_ext  = CMP_W'(width_reg);
    assign height_ext = CMP_W'(height_reg);

    // Sizes beyond the coordinate range act as the full range.
    assign width_lim  = SIZE_BITS'((width_ext  > MAX_SIZE) ? MAX_SIZE : width_ext);
    assign height_lim = SIZE_BITS'((height_ext > MAX_SIZE) ? MAX_SIZE : height_ext);
    assign conn       = conn_reg;

endmodule

`default_nettype wire

// ===== rtl/lr_setup.sv =====
// Line set-up: bounds check, left-to-right ordering and Bresenham deltas.
// Combinational; depends on lr_pkg.
`default_nettype none

module lr_setup #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [lr_pkg::IN_COORD_BITS-1:0] start_x,
    input  wire logic signed [lr_pkg::IN_COORD_BITS-1:0] start_y,
    input  wire logic signed [lr_pkg::IN_COORD_BITS-1:0] end_x,
    input  wire logic signed [lr_pkg::IN_COORD_BITS-1:0] end_y,
    input  wire logic        [COORD_BITS:0]              width_lim,
    input  wire logic        [COORD_BITS:0]              height_lim,
    input  wire logic                                    conn,
    output lr_pkg::lr_flags_t                            flags,
    output logic             [COORD_BITS-1:0]            first_x,
    output logic             [COORD_BITS-1:0]            first_y,
    output logic             [COORD_BITS:0]              major_delta,
    output logic             [COORD_BITS:0]              minor_delta,
    output logic signed      [COORD_BITS+2:0]            error_init,
    output logic             [COORD_BITS:0]              pixel_count
);
    import lr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int CMP_W = (COORD_BITS + 1 > IN_COORD_BITS + 1) ?
                           COORD_BITS + 1 : IN_COORD_BITS + 1;

    function automatic logic in_range(
        input logic signed [IN_COORD_BITS-1:0] v,
        input logic        [COORD_BITS:0]      lim
    );
        logic [CMP_W-1:0] v_ext;
        logic [CMP_W-1:0] lim_ext;
        v_ext   = CMP_W'(unsigned'(v));
        lim_ext = CMP_W'(lim);
        return !v[IN_COORD_BITS-1] && (v_ext < lim_ext);
    endfunction

    logic          ok;
    logic [CB-1:0] ax, ay, bx, by;
    logic          swap;
    logic [CB-1:0] xl, yl, xr, yr;
    logic [CB-1:0] dx, ady;
    logic          y_neg;
    logic          x_major;
    logic [CB-1:0] maj, mnr;

    always_comb
    begin
        ok = in_range(start_x, width_lim) && in_range(end_x, width_lim) &&
             in_range(start_y, height_lim) && in_range(end_y, height_lim);

        ax = start_x[CB-1:0];
        ay = start_y[CB-1:0];
        bx = end_x[CB-1:0];
        by = end_y[CB-1:0];

        // Run left to right.
        swap = bx < ax;
        xl   = swap ? bx : ax;
        yl   = swap ? by : ay;
        xr   = swap ? ax : bx;
        yr   = swap ? ay : by;

        dx      = xr - xl;
        y_neg   = yr < yl;
        ady     = y_neg ? (yl - yr) : (yr - yl);
        x_major = !(ady > dx);
        maj     = x_major ? dx  : ady;
        mnr     = x_major ? ady : dx;
    end

    assign flags.ok      = ok;
    assign flags.x_major = x_major;
    assign flags.y_neg   = y_neg;
    assign flags.conn    = conn;

    assign first_x     = xl;
    assign first_y     = yl;
    assign major_delta = {maj, 1'b0};
    assign minor_delta = {mnr, 1'b0};

    assign error_init = (conn == CONN_8) ?
        $signed(ERR_W'(maj)) - $signed(ERR_W'({mnr, 1'b0})) : '0;

    assign pixel_count = (conn == CONN_8) ?
        ((CB + 1)'(maj) + (CB + 1)'(1)) :
        ((CB + 1)'(maj) + (CB + 1)'(mnr) + (CB + 1)'(1));

endmodule

`default_nettype wire

// ===== rtl/lr_walker.sv =====
// Line walker: Bresenham state, one step per tick, and the pixel output register.
// Depends on lr_pkg.
`default_nettype none

module lr_walker #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire logic                               mode,
    input  wire logic        [lr_pkg::COLOR_BITS-1:0] color,
    input  wire lr_pkg::lr_flags_t                  flags,
    input  wire logic        [COORD_BITS-1:0]       first_x,
    input  wire logic        [COORD_BITS-1:0]       first_y,
    input  wire logic        [COORD_BITS:0]         major_delta,
    input  wire logic        [COORD_BITS:0]         minor_delta,
    input  wire logic signed [COORD_BITS+2:0]       error_init,
    input  wire logic        [COORD_BITS:0]         pixel_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic             [COORD_BITS-1:0]       pix_x,
    output logic             [COORD_BITS-1:0]       pix_y,
    output logic             [lr_pkg::COLOR_BITS-1:0] pix_color,
    output logic                                    last
);
    import lr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int ERR_W = COORD_BITS + 3;

    // Line state.
    logic [CB-1:0]           cur_x_reg, cur_x_next;
    logic [CB-1:0]           cur_y_reg, cur_y_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [CB:0]             maj_reg;
    logic [CB:0]             min_reg;
    logic [CB:0]             left_reg, left_next;
    logic                    x_major_reg;
    logic                    y_neg_reg;
    logic                    conn_reg;
    logic [COLOR_BITS-1:0]   color_reg;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [CB-1:0]           pix_x_reg;
    logic [CB-1:0]           pix_y_reg;
    logic [COLOR_BITS-1:0]   pix_color_reg;
    logic                    last_reg;

    logic                    accept;
    logic                    start_beat;
    logic                    emit;
    logic                    err_neg;
    logic                    move_major;
    logic                    move_minor;
    logic                    step_x;
    logic                    step_y;
    logic signed [ERR_W-1:0] maj_e;
    logic signed [ERR_W-1:0] min_e;

    assign item_ready = !out_valid_reg || out_ready;
    assign accept     = item_valid && item_ready;
    assign start_beat = accept && (mode == MODE_START);
    assign emit       = accept && (mode == MODE_TICK) && (left_reg != '0);

    assign maj_e   = $signed(ERR_W'(maj_reg));
    assign min_e   = $signed(ERR_W'(min_reg));
    assign err_neg = err_reg[ERR_W-1];

    always_comb
    begin
        move_major = 1'b0;
        move_minor = 1'b0;
        err_next   = err_reg;
        if (conn_reg == CONN_8)
        begin
            move_major = 1'b1;
            if (err_neg)
            begin
                move_minor = 1'b1;
                err_next   = err_reg + maj_e - min_e;
            end
            else
            begin
                err_next = err_reg - min_e;
            end
        end
        else
        begin
            if (err_neg)
            begin
                move_minor = 1'b1;
                err_next   = err_reg + maj_e;
            end
            else
            begin
                move_major = 1'b1;
                err_next   = err_reg - min_e;
            end
        end

        step_x = x_major_reg ? move_major : move_minor;
        step_y = x_major_reg ? move_minor : move_major;

        cur_x_next = step_x ? (cur_x_reg + CB'(1)) : cur_x_reg;
        if (!step_y)
            cur_y_next = cur_y_reg;
        else if (y_neg_reg)
            cur_y_next = cur_y_reg - CB'(1);
        else
            cur_y_next = cur_y_reg + CB'(1);

        left_next = left_reg - (CB + 1)'(1);
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (start_beat)
                left_reg <= flags.ok ? pixel_count : '0;
            else if (emit)
                left_reg <= left_next;
        end
    end

    // Stepping past the final pixel is harmless: the next start reloads everything.
    always_ff @(posedge clk)
    begin
        if (start_beat)
        begin
            cur_x_reg   <= first_x;
            cur_y_reg   <= first_y;
            err_reg     <= error_init;
            maj_reg     <= major_delta;
            min_reg     <= minor_delta;
            x_major_reg <= flags.x_major;
            y_neg_reg   <= flags.y_neg;
            conn_reg    <= flags.conn;
            color_reg   <= color;
        end
        else if (emit)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg     <= cur_x_reg;
            pix_y_reg     <= cur_y_reg;
            pix_color_reg <= color_reg;
            last_reg      <= (left_reg == (CB + 1)'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
